/* hdl/fat_volume_cluster_mapper_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the FAT volume cluster mapper checker.
// ----------------------------------------------------------------------------
`ifndef FAT_VOLUME_CLUSTER_MAPPER_ASSERT_SVH
`define FAT_VOLUME_CLUSTER_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FVCM_ASSERT_IMP(lbl, clk_e, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_e) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FVCM_ASSERT_NXT(lbl, clk_e, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_e) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fvcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvcm_pkg
// Shared types and constants of the FAT volume cluster mapper.
// ----------------------------------------------------------------------------
package fvcm_pkg;

	localparam int unsigned CLUSTER_W   = 28;
	localparam int unsigned ENTRY_W     = 32;
	localparam int unsigned SECTOR_W    = 32;
	localparam int unsigned ROOT_CNT_W  = 13;
	localparam int unsigned OFFSET_W    = 12;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned IN_DATA_W   = 64;
	localparam int unsigned OUT_DATA_W  = 224;
	localparam int unsigned OUT_USER_W  = 4;

	localparam logic [SECTOR_W-1:0] FAT12_LIMIT = 32'd4085;
	localparam logic [SECTOR_W-1:0] FAT16_LIMIT = 32'd65525;
	localparam logic [15:0]         FAT16_EOC   = 16'hfff8;
	localparam logic [27:0]         FAT32_EOC   = 28'h0ffffff8;
	localparam logic [3:0]          SEC_LOG2_MIN = 4'd9;
	localparam logic [3:0]          SEC_LOG2_MAX = 4'd12;

	typedef enum logic [1:0] {
		FAT_KIND_12 = 2'd0,
		FAT_KIND_16 = 2'd1,
		FAT_KIND_32 = 2'd2
	} fat_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SECTOR_BYTES_LOG2    = 3'd0,
		REG_CLUSTER_SECTORS_LOG2 = 3'd1,
		REG_RESERVED_SECTORS     = 3'd2,
		REG_FAT_COPIES           = 3'd3,
		REG_ROOT_ENTRIES         = 3'd4,
		REG_TOTAL_SECTORS        = 3'd5,
		REG_SECTORS_PER_FAT      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                 func;
		logic [CLUSTER_W-1:0] cluster;
		logic [ENTRY_W-1:0]   entry_value;
	} in_beat_t;

	// Everything the last stage needs, prepared for both FAT16 and FAT32.
	typedef struct packed {
		logic                  func;
		logic [SECTOR_W-1:0]   root_start;
		logic [ROOT_CNT_W-1:0] root_count;
		logic [SECTOR_W-1:0]   data_start;
		logic [SECTOR_W-1:0]   clus_base;
		logic [SECTOR_W-1:0]   tsec16;
		logic [SECTOR_W-1:0]   tsec32;
		logic [OFFSET_W-1:0]   toff16;
		logic [OFFSET_W-1:0]   toff32;
		logic                  eoc16;
		logic                  eoc32;
		logic [SECTOR_W-1:0]   next_base16;
		logic [SECTOR_W-1:0]   next_base32;
	} mid_beat_t;

endpackage

/* hdl/fat_volume_cluster_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_volume_cluster_mapper
// Maps FAT clusters to sectors and resolves FAT entries from volume geometry.
// ----------------------------------------------------------------------------
// Usage: software writes the volume geometry through cfg_we/cfg_index/cfg_data
// while no beat is in flight. Each slave beat carries a cluster and a raw FAT
// entry in s_axis_tdata and the function in s_axis_tuser (0 maps the cluster
// to its first sector and FAT entry location, 1 resolves the entry into the
// next cluster's first sector or an end-of-chain flag). Every slave beat
// yields exactly one master beat holding the derived geometry and the result.
// The input register feeds two pipeline stages and the output register,
// which compute the FAT size product, root/data area sums, then cluster
// count, type detection and final sector sums. Throughput is one beat per
// cycle while m_axis_tready is high. Each stage moves on when it is empty
// or its successor moves, so a stalled receiver fills the pipeline before
// s_axis_tready falls, and a waiting result does not block acceptance while
// a stage is free.
// Reset empties the pipeline and loads the default geometry.
// ----------------------------------------------------------------------------
module fat_volume_cluster_mapper
	import fvcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [27:0] cluster, [59:28] entry_value, [63:60] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] func
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [31:0] data_start_sector, [63:32] cluster_total, [95:64] root_start_sector,
	// [108:96] root_sector_count, [140:109] cluster_sector, [172:141] table_sector,
	// [184:173] table_offset, [216:185] next_sector, [223:217] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [1:0] fat_kind, [2] chain_end, [3] unsupported
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	// Configuration registers.
	logic [3:0]            sec_log2_q;
	logic [2:0]            clus_log2_q;
	logic [15:0]           reserved_q;
	logic [7:0]            copies_q;
	logic [15:0]           root_entries_q;
	logic [SECTOR_W-1:0]   total_q;
	logic [SECTOR_W-1:0]   spf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_log2_q     <= 4'd9;
			clus_log2_q    <= 3'd0;
			reserved_q     <= 16'd1;
			copies_q       <= 8'd2;
			root_entries_q <= 16'd512;
			total_q        <= '0;
			spf_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SECTOR_BYTES_LOG2:    sec_log2_q     <= cfg_data[3:0];
				REG_CLUSTER_SECTORS_LOG2: clus_log2_q    <= cfg_data[2:0];
				REG_RESERVED_SECTORS:     reserved_q     <= cfg_data[15:0];
				REG_FAT_COPIES:           copies_q       <= cfg_data[7:0];
				REG_ROOT_ENTRIES:         root_entries_q <= cfg_data[15:0];
				REG_TOTAL_SECTORS:        total_q        <= cfg_data;
				REG_SECTORS_PER_FAT:      spf_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sector size is clamped to 512..4096 bytes.
	logic [3:0]          slog;
	logic [OFFSET_W-1:0] sec_mask;

	always_comb begin
		if (sec_log2_q < SEC_LOG2_MIN) begin
			slog = SEC_LOG2_MIN;
		end else if (sec_log2_q > SEC_LOG2_MAX) begin
			slog = SEC_LOG2_MAX;
		end else begin
			slog = sec_log2_q;
		end
		sec_mask = OFFSET_W'((13'd1 << slog) - 13'd1);
	end

	// Pipeline handshake.
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic adv1, adv2, adv3, adv_out;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign adv3          = !v_s3 || adv_out;
	assign adv2          = !v_s2 || adv3;
	assign adv1          = !v_s1 || adv2;
	assign s_axis_tready = adv1;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1)    v_s1        <= s_axis_tvalid;
			if (adv2)    v_s2        <= v_s1;
			if (adv3)    v_s3        <= v_s2;
			if (adv_out) out_valid_q <= v_s3;
		end
	end

	// Stage 1: input register.
	in_beat_t beat_s1;

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			beat_s1.func        <= s_axis_tuser;
			beat_s1.cluster     <= s_axis_tdata[CLUSTER_W-1:0];
			beat_s1.entry_value <= s_axis_tdata[CLUSTER_W+ENTRY_W-1:CLUSTER_W];
		end
	end

	// Stage 2: size of all FAT copies.
	in_beat_t            beat_s2;
	logic [SECTOR_W-1:0] fat_span_s2;
	logic [39:0]         fat_prod;

	assign fat_prod = {32'd0, copies_q} * {8'd0, spf_q};

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			beat_s2     <= beat_s1;
			fat_span_s2 <= fat_prod[SECTOR_W-1:0];
		end
	end

	// Stage 3: root and data areas, per-type candidates of the results.
	mid_beat_t mid_d, mid_s3;

	always_comb begin
		logic [20:0]         dir_bytes;
		logic [21:0]         dir_round;
		logic [SECTOR_W-1:0] boff16;
		logic [SECTOR_W-1:0] boff32;
		logic [15:0]         val16;
		logic [27:0]         val32;

		dir_bytes = {root_entries_q, 5'd0};
		dir_round = {1'b0, dir_bytes} + {10'd0, sec_mask};
		boff16    = {3'd0, beat_s2.cluster, 1'b0};
		boff32    = {2'd0, beat_s2.cluster, 2'b0};
		val16     = beat_s2.entry_value[15:0];
		val32     = beat_s2.entry_value[27:0];

		mid_d.func        = beat_s2.func;
		mid_d.root_start  = {16'd0, reserved_q} + fat_span_s2;
		mid_d.root_count  = ROOT_CNT_W'(dir_round >> slog);
		mid_d.data_start  = mid_d.root_start + {19'd0, mid_d.root_count};
		mid_d.clus_base   = ({4'd0, beat_s2.cluster} - 32'd2) << clus_log2_q;
		mid_d.tsec16      = {16'd0, reserved_q} + (boff16 >> slog);
		mid_d.tsec32      = {16'd0, reserved_q} + (boff32 >> slog);
		mid_d.toff16      = boff16[OFFSET_W-1:0] & sec_mask;
		mid_d.toff32      = boff32[OFFSET_W-1:0] & sec_mask;
		mid_d.eoc16       = (val16 >= FAT16_EOC);
		mid_d.eoc32       = (val32 >= FAT32_EOC);
		mid_d.next_base16 = ({16'd0, val16} - 32'd2) << clus_log2_q;
		mid_d.next_base32 = ({4'd0, val32} - 32'd2) << clus_log2_q;
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			mid_s3 <= mid_d;
		end
	end

	// Final stage: cluster count, FAT type and mode selection.
	logic [SECTOR_W-1:0]   clusters;
	fat_kind_t             kind;
	logic [SECTOR_W-1:0]   clus_sec;
	logic [SECTOR_W-1:0]   tab_sec;
	logic [OFFSET_W-1:0]   tab_off;
	logic [SECTOR_W-1:0]   nxt_sec;
	logic                  eoc;

	always_comb begin
		logic [SECTOR_W-1:0] data_secs;
		logic [SECTOR_W-1:0] nbase;
		logic                eoc_sel;

		data_secs = total_q - mid_s3.data_start;
		clusters  = data_secs >> clus_log2_q;
		if (clusters < FAT12_LIMIT) begin
			kind = FAT_KIND_12;
		end else if (clusters < FAT16_LIMIT) begin
			kind = FAT_KIND_16;
		end else begin
			kind = FAT_KIND_32;
		end

		nbase   = (kind == FAT_KIND_16) ? mid_s3.next_base16 : mid_s3.next_base32;
		eoc_sel = (kind == FAT_KIND_16) ? mid_s3.eoc16 : mid_s3.eoc32;

		clus_sec = '0;
		tab_sec  = '0;
		tab_off  = '0;
		nxt_sec  = '0;
		eoc      = 1'b0;
		if (!mid_s3.func) begin
			clus_sec = mid_s3.clus_base + mid_s3.data_start;
			if (kind != FAT_KIND_12) begin
				tab_sec = (kind == FAT_KIND_16) ? mid_s3.tsec16 : mid_s3.tsec32;
				tab_off = (kind == FAT_KIND_16) ? mid_s3.toff16 : mid_s3.toff32;
			end
		end else if (kind != FAT_KIND_12) begin
			eoc     = eoc_sel;
			nxt_sec = eoc_sel ? '0 : (nbase + mid_s3.data_start);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv_out && v_s3) begin
			m_axis_tdata <= {7'd0, nxt_sec, tab_off, tab_sec, clus_sec,
				mid_s3.root_count, mid_s3.root_start, clusters, mid_s3.data_start};
			m_axis_tuser <= {(kind == FAT_KIND_12), eoc, kind};
		end
	end

endmodule

/* hdl/fvcm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvcm_checker
// Port-level checks of the FAT volume cluster mapper result stream.
// ----------------------------------------------------------------------------
`include "fat_volume_cluster_mapper_assert.svh"

module fvcm_checker
	import fvcm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	logic                is_fat12;
	logic                chain_end;
	logic                unsupported;
	logic [SECTOR_W-1:0] cluster_sector;
	logic [SECTOR_W-1:0] table_sector;
	logic [OFFSET_W-1:0] table_offset;
	logic [SECTOR_W-1:0] next_sector;

	assign is_fat12       = (fat_kind_t'(m_axis_tuser[1:0]) == FAT_KIND_12);
	assign chain_end      = m_axis_tuser[2];
	assign unsupported    = m_axis_tuser[3];
	assign cluster_sector = m_axis_tdata[140:109];
	assign table_sector   = m_axis_tdata[172:141];
	assign table_offset   = m_axis_tdata[184:173];
	assign next_sector    = m_axis_tdata[216:185];

	// A stalled result beat holds still.
	`FVCM_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"result beat changed while stalled")

	`FVCM_ASSERT_IMP(a_unsup, clk, arst_n, m_axis_tvalid,
		unsupported == is_fat12, "unsupported flag disagrees with FAT type")

	// End of chain only comes from an entry lookup, which leaves the map fields clear.
	`FVCM_ASSERT_IMP(a_eoc, clk, arst_n, m_axis_tvalid && chain_end,
		next_sector == '0 && cluster_sector == '0 && table_sector == '0,
		"end of chain with sector fields set")

	`FVCM_ASSERT_IMP(a_fat12, clk, arst_n, m_axis_tvalid && is_fat12,
		table_sector == '0 && table_offset == '0 && next_sector == '0 && !chain_end,
		"FAT12 volume produced table or chain results")

endmodule

bind fat_volume_cluster_mapper fvcm_checker u_fvcm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
